// ===== rtl/core/sact_pkg.sv =====
`timescale 1ns / 1ps

package sact_pkg;

  // Field widths of the request and response beats
  localparam int ADDR_W = 32;
  localparam int CNT_W  = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Victim order selected by the configuration register
  typedef enum logic {
    MODE_LRU  = 1'b0,
    MODE_FIFO = 1'b1
  } repl_mode_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } ctl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear_wr;  // write one zero row of the clearing pass
    logic accept;    // take the request beat and read its set
    logic update;    // resolve the lookup, write the set back, load the result
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last;  // clearing pass is at its last row
    logic out_busy;    // result register holds a beat that is not taken this cycle
  } dp_sts_t;

endpackage

// ===== rtl/core/sact_req_if.sv =====
`timescale 1ns / 1ps

interface sact_req_if import sact_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              wr_req;

  modport source (output valid, output address, output wr_req, input ready);
  modport sink (input valid, input address, input wr_req, output ready);
endinterface

// ===== rtl/core/sact_rsp_if.sv =====
`timescale 1ns / 1ps

interface sact_rsp_if import sact_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic             replaced;
  logic             victim_was_dirty;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;

  modport source (output valid, output hit, output replaced, output victim_was_dirty,
                  output hit_total, output miss_total, input ready);
  modport sink (input valid, input hit, input replaced, input victim_was_dirty,
                input hit_total, input miss_total, output ready);
endinterface

// ===== rtl/core/set_assoc_cache_tag_lookup.sv =====
`timescale 1ns / 1ps

// Tag store of a set-associative cache with LRU or FIFO victim order. Each request beat
// carries a byte address and a write flag; the response beat reports hit, whether a valid
// line was evicted and its dirty mark, and the saturating hit and miss totals including
// this access. The ways of a set live in one row of a single-port tag memory, so an
// access has two steps: the first reads the set row, the second compares all ways, picks the
// victim and writes the row back. A finished response waits in an output register while
// the next request is taken. After reset the block sweeps the tag memory once, one set
// per cycle, with in_req.ready low. The user must write replacement_mode through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce this.
module set_assoc_cache_tag_lookup import sact_pkg::*; #(
  parameter int WAYS        = 4,
  parameter int SETS        = 64,
  parameter int BLOCK_BYTES = 64,
  parameter int ADDR_BITS   = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  sact_req_if.sink   in_req,
  sact_rsp_if.source out_rsp
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  sact_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sact_dpath #(
    .WAYS        (WAYS),
    .SETS        (SETS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_address           (in_req.address),
    .in_wr_req            (in_req.wr_req),
    .out_ready            (out_rsp.ready),
    .out_valid            (out_rsp.valid),
    .out_hit              (out_rsp.hit),
    .out_replaced         (out_rsp.replaced),
    .out_victim_was_dirty (out_rsp.victim_was_dirty),
    .out_hit_total        (out_rsp.hit_total),
    .out_miss_total       (out_rsp.miss_total)
  );

endmodule

// ===== rtl/core/sact_ctrl.sv =====
`timescale 1ns / 1ps

module sact_ctrl import sact_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_sts_t   sts,
  output ctl_cmd_t  cmd
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_LOOKUP: begin
        cmd.update = !sts.out_busy;
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/sact_dpath.sv =====
`timescale 1ns / 1ps

module sact_dpath import sact_pkg::*; #(
  parameter int WAYS        = 4,
  parameter int SETS        = 64,
  parameter int BLOCK_BYTES = 64,
  parameter int ADDR_BITS   = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_cmd_t          cmd,
  output dp_sts_t           sts,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic [ADDR_W-1:0] in_address,
  input  logic              in_wr_req,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_hit,
  output logic              out_replaced,
  output logic              out_victim_was_dirty,
  output logic [CNT_W-1:0]  out_hit_total,
  output logic [CNT_W-1:0]  out_miss_total
);

  // Address split: floor(log2) of the block and set counts
  localparam int OFF_BITS = $clog2(BLOCK_BYTES + 1) - 1;
  localparam int IDX_BITS = $clog2(SETS + 1) - 1;
  localparam int NSETS    = 1 << IDX_BITS;
  localparam int IDX_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int EFF_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int TAG_BITS = EFF_BITS - OFF_BITS - IDX_BITS;
  localparam int TAG_W    = (TAG_BITS > 0) ? TAG_BITS : 1;
  localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  // One line: {valid, dirty, rank, tag}
  localparam int LINE_W   = 2 + RANK_W + TAG_W;
  localparam int ROW_W    = WAYS * LINE_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - EFF_BITS);

  // Tag store: one row per set holding every way
  logic [ROW_W-1:0] mem [NSETS];
  logic [ROW_W-1:0] rd_row_r;
  logic [ROW_W-1:0] wr_row;
  logic [ROW_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_we;

  logic [IDX_W-1:0] clr_idx_r;
  repl_mode_t       mode_r;
  logic [IDX_W-1:0] req_set_r;
  logic [TAG_W-1:0] req_tag_r;
  logic             req_wr_r;
  logic [CNT_W-1:0] hit_cnt_r;
  logic [CNT_W-1:0] hit_cnt_nxt;
  logic [CNT_W-1:0] miss_cnt_r;
  logic [CNT_W-1:0] miss_cnt_nxt;
  logic             out_valid_r;
  logic             out_hit_r;
  logic             out_repl_r;
  logic             out_vdirty_r;

  // Request address split
  logic [ADDR_W-1:0] addr_m;
  logic [ADDR_W-1:0] set_full;
  logic [ADDR_W-1:0] tag_full;
  logic [IDX_W-1:0]  in_set;
  logic [TAG_W-1:0]  in_tag;

  assign addr_m   = in_address & ADDR_MASK;
  assign set_full = addr_m >> OFF_BITS;
  assign tag_full = addr_m >> (OFF_BITS + IDX_BITS);
  assign in_set   = (IDX_BITS > 0) ? set_full[IDX_W-1:0] : '0;
  assign in_tag   = tag_full[TAG_W-1:0];

  // Unpack the set read from the store
  logic [WAYS-1:0]   ln_valid;
  logic [WAYS-1:0]   ln_dirty;
  logic [RANK_W-1:0] ln_rank [WAYS];
  logic [TAG_W-1:0]  ln_tag  [WAYS];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      ln_tag[w]   = rd_row_r[w*LINE_W +: TAG_W];
      ln_rank[w]  = rd_row_r[w*LINE_W + TAG_W +: RANK_W];
      ln_dirty[w] = rd_row_r[w*LINE_W + TAG_W + RANK_W];
      ln_valid[w] = rd_row_r[w*LINE_W + TAG_W + RANK_W + 1];
    end
  end

  // Compare all ways and pick the hit way and the victim
  logic [WAYS-1:0]   hit_vec;
  logic [WAYS-1:0]   hit_sel;
  logic [WAYS-1:0]   inv_sel;
  logic [WAYS-1:0]   old_sel;
  logic [WAYS-1:0]   vic_sel;
  logic              hit_any;
  logic              set_full_w;
  logic [RANK_W-1:0] hit_rank;
  logic              vic_dirty;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = ln_valid[w] && (ln_tag[w] == req_tag_r);
    end
    hit_sel    = hit_vec & (~hit_vec + 1'b1);
    inv_sel    = ~ln_valid & (ln_valid + 1'b1);
    hit_any    = |hit_vec;
    set_full_w = &ln_valid;
    // Oldest way: largest rank, lowest way among equals
    for (int w = 0; w < WAYS; w++) begin
      old_sel[w] = 1'b1;
      for (int v = 0; v < WAYS; v++) begin
        if (v < w) begin
          if (ln_rank[w] <= ln_rank[v]) old_sel[w] = 1'b0;
        end else if (v > w) begin
          if (ln_rank[w] < ln_rank[v]) old_sel[w] = 1'b0;
        end
      end
    end
    vic_sel  = set_full_w ? old_sel : inv_sel;
    hit_rank = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_sel[w]) hit_rank = hit_rank | ln_rank[w];
    end
    vic_dirty = set_full_w && |(ln_dirty & old_sel);
  end

  // Build the updated row
  always_comb begin
    logic              nv;
    logic              nd;
    logic [RANK_W-1:0] nr;
    logic [TAG_W-1:0]  nt;
    wr_row = rd_row_r;
    for (int w = 0; w < WAYS; w++) begin
      nv = ln_valid[w];
      nd = ln_dirty[w];
      nr = ln_rank[w];
      nt = ln_tag[w];
      if (hit_any) begin
        if (hit_sel[w] && req_wr_r) nd = 1'b1;
        if (mode_r == MODE_LRU) begin
          if (hit_sel[w]) begin
            nr = '0;
          end else if (ln_valid[w] && (ln_rank[w] < hit_rank)) begin
            nr = RANK_W'(ln_rank[w] + 1'b1);
          end
        end
      end else begin
        if (vic_sel[w]) begin
          nv = 1'b1;
          nd = req_wr_r;
          nr = '0;
          nt = req_tag_r;
        end else if (ln_valid[w]) begin
          nr = RANK_W'(ln_rank[w] + 1'b1);
        end
      end
      wr_row[w*LINE_W +: LINE_W] = {nv, nd, nr, nt};
    end
  end

  // Store write port: clearing pass or write-back
  assign mem_we    = cmd.clear_wr || cmd.update;
  assign mem_waddr = cmd.clear_wr ? clr_idx_r : req_set_r;
  assign mem_wdata = cmd.clear_wr ? '0 : wr_row;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) rd_row_r <= mem[in_set];
  end

  // Hold the request fields for the update cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_set_r <= in_set;
      req_tag_r <= in_tag;
      req_wr_r  <= in_wr_req;
    end
  end

  // Saturating totals
  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (hit_any) begin
      if (hit_cnt_r != CNT_MAX) hit_cnt_nxt = hit_cnt_r + 1'b1;
    end else begin
      if (miss_cnt_r != CNT_MAX) miss_cnt_nxt = miss_cnt_r + 1'b1;
    end
  end

  // Control registers: mode, clear counter, totals, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_LRU;
      clr_idx_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= repl_mode_t'(cfg_wr_data);
      if (cmd.clear_wr) clr_idx_r <= IDX_W'(clr_idx_r + 1'b1);
      if (cmd.update) begin
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r    <= hit_any;
      out_repl_r   <= !hit_any && set_full_w;
      out_vdirty_r <= !hit_any && vic_dirty;
    end
  end

  assign sts.clear_last = (clr_idx_r == IDX_W'(NSETS - 1));
  assign sts.out_busy   = out_valid_r && !out_ready;

  assign out_valid            = out_valid_r;
  assign out_hit              = out_hit_r;
  assign out_replaced         = out_repl_r;
  assign out_victim_was_dirty = out_vdirty_r;
  assign out_hit_total        = hit_cnt_r;
  assign out_miss_total       = miss_cnt_r;

endmodule

// ===== test/lookup_checker.sv =====
`timescale 1ns / 1ps

module lookup_checker import sact_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  sact_req_if  req_mon,
  sact_rsp_if  rsp_mon,
  output int   fail_count,
  output int   outstanding,
  output int   access_count,
  output int   hit_count_seen,
  output int   evict_count,
  output int   dirty_evict_count
);

  localparam int NUM_WAYS    = 4;
  localparam int SHADOW_SETS = 64;
  localparam int OFFSET_W    = 6;
  localparam int INDEX_W     = 6;
  localparam int TAG_W       = ADDR_W - OFFSET_W - INDEX_W;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic             hit;
    logic             replaced;
    logic             victim_was_dirty;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
  } lookup_result_t;

  // Shadow copy of the tag store
  logic             way_valid [SHADOW_SETS][NUM_WAYS];
  logic [TAG_W-1:0] way_tag   [SHADOW_SETS][NUM_WAYS];
  logic             way_dirty [SHADOW_SETS][NUM_WAYS];
  logic [1:0]       way_rank  [SHADOW_SETS][NUM_WAYS];
  logic [CNT_W-1:0] hit_tally;
  logic [CNT_W-1:0] miss_tally;
  repl_mode_t       victim_order;

  lookup_result_t pending_responses [$];

  task automatic report_mismatch(input string what, input logic [CNT_W-1:0] want,
                                 input logic [CNT_W-1:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t ns mismatch: %s, expected %0h, got %0h", $time, what, want, got);
  endtask

  // Age every valid line of the set whose rank is below the limit
  function automatic void age_set(input logic [INDEX_W-1:0] set_idx, input int limit);
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (way_valid[set_idx][w] && int'(way_rank[set_idx][w]) < limit)
        way_rank[set_idx][w] = way_rank[set_idx][w] + 2'd1;
    end
  endfunction

  // Look up one access, update the shadow store and return the response it causes
  function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr,
                                                    input logic wr);
    logic [INDEX_W-1:0] set_idx;
    logic [TAG_W-1:0]   tag;
    int                 hit_way;
    int                 fill_way;
    lookup_result_t     res;
    res     = '0;
    set_idx = addr[OFFSET_W +: INDEX_W];
    tag     = addr[ADDR_W-1 -: TAG_W];
    hit_way = -1;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (hit_way < 0 && way_valid[set_idx][w] && way_tag[set_idx][w] == tag)
        hit_way = w;
    end
    if (hit_way >= 0) begin
      res.hit = 1'b1;
      if (hit_tally != CNT_MAX)
        hit_tally = hit_tally + 1'b1;
      if (wr)
        way_dirty[set_idx][hit_way] = 1'b1;
      // LRU moves the line to the front; FIFO keeps the fill order
      if (victim_order == MODE_LRU) begin
        age_set(set_idx, int'(way_rank[set_idx][hit_way]));
        way_rank[set_idx][hit_way] = 2'd0;
      end
    end else begin
      if (miss_tally != CNT_MAX)
        miss_tally = miss_tally + 1'b1;
      fill_way = -1;
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (fill_way < 0 && !way_valid[set_idx][w])
          fill_way = w;
      end
      // Full set: evict the oldest line, lowest way on a tie
      if (fill_way < 0) begin
        fill_way = 0;
        for (int w = 1; w < NUM_WAYS; w++) begin
          if (way_rank[set_idx][w] > way_rank[set_idx][fill_way])
            fill_way = w;
        end
        res.replaced         = 1'b1;
        res.victim_was_dirty = way_dirty[set_idx][fill_way];
        way_valid[set_idx][fill_way] = 1'b0;
      end
      age_set(set_idx, NUM_WAYS);
      way_valid[set_idx][fill_way] = 1'b1;
      way_tag[set_idx][fill_way]   = tag;
      way_dirty[set_idx][fill_way] = wr;
      way_rank[set_idx][fill_way]  = 2'd0;
    end
    res.hit_total  = hit_tally;
    res.miss_total = miss_tally;
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    lookup_result_t want;
    if (!rst_n) begin
      // Clear the shadow store and all bookkeeping
      for (int s = 0; s < SHADOW_SETS; s++) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          way_valid[s][w] = 1'b0;
          way_tag[s][w]   = '0;
          way_dirty[s][w] = 1'b0;
          way_rank[s][w]  = 2'd0;
        end
      end
      hit_tally         = '0;
      miss_tally        = '0;
      victim_order      = MODE_LRU;
      fail_count        = 0;
      access_count      = 0;
      hit_count_seen    = 0;
      evict_count       = 0;
      dirty_evict_count = 0;
      pending_responses.delete();
      outstanding <= 0;
    end else begin
      // Predict each accepted request beat
      if (req_mon.valid && req_mon.ready) begin
        want = predict_lookup(req_mon.address, req_mon.wr_req);
        pending_responses.insert(pending_responses.size(), want);
        access_count++;
        if (want.hit)
          hit_count_seen++;
        if (want.replaced)
          evict_count++;
        if (want.victim_was_dirty)
          dirty_evict_count++;
      end
      // Mode change applies from the next access on
      if (cfg_wr_en)
        victim_order = repl_mode_t'(cfg_wr_data);
      // Compare each accepted response beat with the oldest prediction
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pending_responses.size() == 0) begin
          report_mismatch("response beat with nothing pending", '0, '0);
        end else begin
          want = pending_responses[0];
          pending_responses.delete(0);
          if (rsp_mon.hit !== want.hit)
            report_mismatch("hit", CNT_W'(want.hit), CNT_W'(rsp_mon.hit));
          if (rsp_mon.replaced !== want.replaced)
            report_mismatch("replaced", CNT_W'(want.replaced), CNT_W'(rsp_mon.replaced));
          if (rsp_mon.victim_was_dirty !== want.victim_was_dirty)
            report_mismatch("victim_was_dirty", CNT_W'(want.victim_was_dirty),
                            CNT_W'(rsp_mon.victim_was_dirty));
          if (rsp_mon.hit_total !== want.hit_total)
            report_mismatch("hit_total", want.hit_total, rsp_mon.hit_total);
          if (rsp_mon.miss_total !== want.miss_total)
            report_mismatch("miss_total", want.miss_total, rsp_mon.miss_total);
        end
      end
      outstanding <= pending_responses.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import sact_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int OFFSET_W     = 6;
  localparam int INDEX_W      = 6;
  localparam int TAG_W        = ADDR_W - OFFSET_W - INDEX_W;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 150;

  localparam logic [TAG_W-1:0] TAG_POOL [6] = '{20'h00000, 20'hFFFFF, 20'h00001,
                                                 20'h80000, 20'hAAAAA, 20'h55555};
  localparam logic [INDEX_W-1:0] HOT_SETS [4] = '{6'd0, 6'd63, 6'd21, 6'd42};

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  int fails;
  int pending;
  int accesses;
  int hits;
  int evictions;
  int dirty_evictions;
  int cycle_count = 0;
  int rx_hold     = 0;
  bit rx_eager    = 1'b0;
  bit tx_eager    = 1'b0;

  sact_req_if req_bus ();
  sact_rsp_if rsp_bus ();

  set_assoc_cache_tag_lookup i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_req      (req_bus),
    .out_rsp     (rsp_bus)
  );

  lookup_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .req_mon           (req_bus),
    .rsp_mon           (rsp_bus),
    .fail_count        (fails),
    .outstanding       (pending),
    .access_count      (accesses),
    .hit_count_seen    (hits),
    .evict_count       (evictions),
    .dirty_evict_count (dirty_evictions)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Response side: random stalls, bursts, and one long hold-off on request
  initial begin : receiver
    int stall;
    rsp_bus.ready = 1'b0;
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else if (rx_eager) begin
        stall = 0;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      end
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_bus.valid && rsp_bus.ready));
    end
  end

  function automatic logic [ADDR_W-1:0] make_addr(input logic [TAG_W-1:0] tag,
                                                  input logic [INDEX_W-1:0] set_idx,
                                                  input logic [OFFSET_W-1:0] offset);
    return {tag, set_idx, offset};
  endfunction

  // Offer one request beat after a random gap and hold it until taken
  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic wr);
    int gap;
    gap = (tx_eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid   <= 1'b1;
    req_bus.address <= addr;
    req_bus.wr_req  <= wr;
    do @(posedge clk); while (!(req_bus.valid && req_bus.ready));
  endtask

  // Mostly a few hot sets with a small tag pool, the rest any address
  task automatic send_random();
    logic [ADDR_W-1:0] addr;
    if ($urandom_range(0, 99) < 85)
      addr = make_addr(TAG_POOL[$urandom_range(0, 5)], HOT_SETS[$urandom_range(0, 3)],
                       OFFSET_W'($urandom_range(0, 63)));
    else
      addr = $urandom();
    send_access(addr, 1'($urandom_range(0, 1)));
  endtask

  // Drop valid and wait until every predicted response has been taken
  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_mode(input repl_mode_t mode);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = MODE_LRU;
    req_bus.valid   = 1'b0;
    req_bus.address = '0;
    req_bus.wr_req  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // LRU after reset: address extremes, hits on both, then fill and thrash one set
    send_access(make_addr('0, 6'd0, 6'd0), 1'b0);
    send_access({ADDR_W{1'b1}}, 1'b1);
    send_access(make_addr('0, 6'd0, 6'd63), 1'b0);
    send_access(make_addr('0, 6'd0, 6'd0), 1'b1);
    send_access(make_addr({TAG_W{1'b1}}, 6'd63, 6'd0), 1'b0);
    for (int t = 1; t <= 4; t++)
      send_access(make_addr(TAG_W'(t), 6'd5, OFFSET_W'(t * 7)), t == 3);
    send_access(make_addr(TAG_W'(1), 6'd5, 6'd0), 1'b0);
    send_access(make_addr(TAG_W'(5), 6'd5, 6'd0), 1'b0);
    send_access(make_addr(TAG_W'(6), 6'd5, 6'd0), 1'b1);
    send_access(make_addr(TAG_W'(4), 6'd5, 6'd0), 1'b1);
    send_access(make_addr(TAG_W'(7), 6'd5, 6'd0), 1'b0);

    // FIFO: a hit does not save the first-filled line from eviction
    set_mode(MODE_FIFO);
    for (int t = 1; t <= 4; t++)
      send_access(make_addr(TAG_W'(t), 6'd9, 6'd0), 1'b0);
    send_access(make_addr(TAG_W'(1), 6'd9, 6'd0), 1'b1);
    send_access(make_addr(TAG_W'(2), 6'd9, 6'd0), 1'b0);
    send_access(make_addr(TAG_W'(5), 6'd9, 6'd0), 1'b0);
    send_access(make_addr(TAG_W'(6), 6'd9, 6'd0), 1'b1);

    // Random phases, alternating victim order
    for (int phase = 0; phase < PHASES; phase++) begin
      set_mode((phase % 2 == 1) ? MODE_FIFO : MODE_LRU);
      tx_eager = (phase == 2);
      rx_eager = (phase == 2);
      if (phase == 3)
        rx_hold = 80;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3)
          tx_eager = (n < 30);
        if (phase == 4 && n == PHASE_ITEMS / 2)
          wait_idle();
        send_random();
      end
    end
    tx_eager = 1'b0;
    rx_eager = 1'b0;

    // Drain and watch for stray beats
    wait_idle();
    repeat (8) @(posedge clk);
    $display("Covered %0d accesses in LRU and FIFO order: %0d hits, %0d evictions (%0d dirty)",
             accesses, hits, evictions, dirty_evictions);
    $display("Traffic included bursts, a long response hold-off and a full drain mid-phase");
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
